### rtl/core/mlfr_pkg.sv
// ----------------------------------------------------------------------------
// mlfr_pkg
// Shared types and constants of the magic/length frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfr_pkg;

    localparam logic [7:0]  MAGIC_FIRST      = 8'hAA;
    localparam logic [7:0]  MAGIC_SECOND     = 8'hBB;
    localparam logic [31:0] MAX_LENGTH_RESET = 32'd36864;

    // Event codes carried in event_res.
    localparam logic [1:0] EV_DATA   = 2'd0;
    localparam logic [1:0] EV_HEADER = 2'd1;
    localparam logic [1:0] EV_ERROR  = 2'd2;

    // Number of results the queue between front and back can hold.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [7:0] {
        PH_HUNT   = 8'b0000_0001,
        PH_MAGIC2 = 8'b0000_0010,
        PH_TYPE   = 8'b0000_0100,
        PH_LEN0   = 8'b0000_1000,
        PH_LEN1   = 8'b0001_0000,
        PH_LEN2   = 8'b0010_0000,
        PH_LEN3   = 8'b0100_0000,
        PH_DATA   = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  frame_type;
        logic [31:0] frame_length;
        logic [7:0]  data_byte;
        logic        last;
    } t_result;

    // Status that the queue reports to the front and back parts.
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_queue_status;

endpackage : mlfr_pkg

`default_nettype wire

### rtl/core/magic_length_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// magic_length_frame_receiver_unit
// Deframer for 0xAA 0xBB framed, length-prefixed byte streams.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-----------------------------------
//  input   | in        | i_valid / o_stall   | i_rx_byte
//  output  | out       | o_valid / i_stall   | o_event_res, o_frame_type,
//          |           |                     | o_frame_length, o_data_byte, o_last
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (max_length)
//
//  One byte is taken every cycle unless the queue is full; the phase update and
//  length compare in the front part set that figure. A result passes through the
//  queue and the output register to o_valid. Reset is synchronous and needs no
//  clearing pass. o_stall rises only when the two-entry result queue is full, so
//  a stall on the output side reaches the input side after the queue has filled.
// ----------------------------------------------------------------------------
`default_nettype none

module magic_length_frame_receiver_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_stall,
    input  wire logic        i_cfg_valid,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_cfg_ready,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_event_res,
    output logic [7:0]       o_frame_type,
    output logic [31:0]      o_frame_length,
    output logic [7:0]       o_data_byte,
    output logic             o_last
);

    mlfr_pkg::t_queue_status q_status;
    mlfr_pkg::t_result       front_result;
    mlfr_pkg::t_result       q_data;
    mlfr_pkg::t_result       out_result;
    logic                    push;
    logic                    pop;

    mlfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_rx_byte   (i_rx_byte),
        .o_stall     (o_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_result    (front_result)
    );

    mlfr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_result),
        .i_pop    (pop),
        .o_data   (q_data),
        .o_status (q_status)
    );

    mlfr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_q_data   (q_data),
        .o_pop      (pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_result   (out_result)
    );

    assign o_event_res    = out_result.event_res;
    assign o_frame_type   = out_result.frame_type;
    assign o_frame_length = out_result.frame_length;
    assign o_data_byte    = out_result.data_byte;
    assign o_last         = out_result.last;

endmodule : magic_length_frame_receiver_unit

`default_nettype wire

### rtl/core/mlfr_front.sv
// ----------------------------------------------------------------------------
// mlfr_front
// Takes received bytes, tracks the frame phase and builds result items.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfr_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic [7:0]               i_rx_byte,
    output logic                          o_stall,
    input  wire logic                     i_cfg_valid,
    input  wire logic [31:0]              i_cfg_data,
    output logic                          o_cfg_ready,
    input  wire mlfr_pkg::t_queue_status  i_q_status,
    output logic                          o_push,
    output mlfr_pkg::t_result             o_result
);

    mlfr_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_type, n_type;
    logic [31:0]      r_len, n_len;
    logic [31:0]      r_left, n_left;
    logic [31:0]      r_max_length;
    logic             accept;
    logic             emit;
    logic [31:0]      len_shift;
    logic [31:0]      left_dec;

    assign o_stall     = i_q_status.full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !i_q_status.full;
    assign o_push      = accept && emit;

    assign len_shift = {r_len[23:0], i_rx_byte};
    assign left_dec  = (r_left != 32'd0) ? (r_left - 32'd1) : 32'd0;

    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_len    = r_len;
        n_left   = r_left;
        emit     = 1'b0;
        o_result = '0;
        o_result.frame_type   = r_type;
        o_result.frame_length = r_len;
        unique case (r_phase)
            mlfr_pkg::PH_HUNT: begin
                if (i_rx_byte == mlfr_pkg::MAGIC_FIRST) begin
                    n_phase = mlfr_pkg::PH_MAGIC2;
                end
            end
            mlfr_pkg::PH_MAGIC2: begin
                n_phase = (i_rx_byte == mlfr_pkg::MAGIC_SECOND) ?
                          mlfr_pkg::PH_TYPE : mlfr_pkg::PH_HUNT;
            end
            mlfr_pkg::PH_TYPE: begin
                n_type  = i_rx_byte;
                n_len   = 32'd0;
                n_phase = mlfr_pkg::PH_LEN0;
            end
            mlfr_pkg::PH_LEN0: begin
                n_len   = len_shift;
                n_phase = mlfr_pkg::PH_LEN1;
            end
            mlfr_pkg::PH_LEN1: begin
                n_len   = len_shift;
                n_phase = mlfr_pkg::PH_LEN2;
            end
            mlfr_pkg::PH_LEN2: begin
                n_len   = len_shift;
                n_phase = mlfr_pkg::PH_LEN3;
            end
            mlfr_pkg::PH_LEN3: begin
                n_len                 = len_shift;
                emit                  = 1'b1;
                o_result.frame_length = len_shift;
                if (len_shift > r_max_length) begin
                    o_result.event_res = mlfr_pkg::EV_ERROR;
                    n_phase            = mlfr_pkg::PH_HUNT;
                end else if (len_shift == 32'd0) begin
                    o_result.event_res = mlfr_pkg::EV_HEADER;
                    o_result.last      = 1'b1;
                    n_phase            = mlfr_pkg::PH_HUNT;
                end else begin
                    o_result.event_res = mlfr_pkg::EV_HEADER;
                    n_left             = len_shift;
                    n_phase            = mlfr_pkg::PH_DATA;
                end
            end
            mlfr_pkg::PH_DATA: begin
                emit               = 1'b1;
                n_left             = left_dec;
                o_result.event_res = mlfr_pkg::EV_DATA;
                o_result.data_byte = i_rx_byte;
                o_result.last      = (left_dec == 32'd0);
                if (left_dec == 32'd0) begin
                    n_phase = mlfr_pkg::PH_HUNT;
                end
            end
            default: begin
                n_phase = mlfr_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= mlfr_pkg::PH_HUNT;
            r_type       <= 8'd0;
            r_len        <= 32'd0;
            r_left       <= 32'd0;
            r_max_length <= mlfr_pkg::MAX_LENGTH_RESET;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_type  <= n_type;
                r_len   <= n_len;
                r_left  <= n_left;
            end
            if (i_cfg_valid) begin
                r_max_length <= i_cfg_data;
            end
        end
    end

endmodule : mlfr_front

`default_nettype wire

### rtl/core/mlfr_queue.sv
// ----------------------------------------------------------------------------
// mlfr_queue
// Short result queue that lets the front and back parts stall on their own.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfr_queue (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    input  wire mlfr_pkg::t_result       i_data,
    input  wire logic                    i_pop,
    output mlfr_pkg::t_result            o_data,
    output mlfr_pkg::t_queue_status      o_status
);

    localparam int unsigned AW = mlfr_pkg::QUEUE_AW;
    localparam int unsigned CW = mlfr_pkg::QUEUE_CW;

    mlfr_pkg::t_result r_mem [mlfr_pkg::QUEUE_DEPTH];
    logic [AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]     r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_status.full      = (r_count == CW'(mlfr_pkg::QUEUE_DEPTH));
    assign o_status.not_empty = (r_count != '0);
    assign o_data             = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && o_status.not_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(mlfr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(mlfr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule : mlfr_queue

`default_nettype wire

### rtl/core/mlfr_back.sv
// ----------------------------------------------------------------------------
// mlfr_back
// Output register stage that presents results and holds them while stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfr_back (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire mlfr_pkg::t_queue_status i_q_status,
    input  wire mlfr_pkg::t_result       i_q_data,
    output logic                         o_pop,
    input  wire logic                    i_stall,
    output logic                         o_valid,
    output mlfr_pkg::t_result            o_result
);

    logic              r_valid;
    mlfr_pkg::t_result r_result;

    // A queued result loads if the register is empty or its transfer ends now.
    assign o_pop    = i_q_status.not_empty && (!r_valid || !i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_q_status.not_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_q_data;
        end
    end

endmodule : mlfr_back

`default_nettype wire

### rtl/core/mlfr_checker.sv
// ----------------------------------------------------------------------------
// mlfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_event_res,
    input wire logic [7:0]  o_data_byte,
    input wire logic [31:0] o_frame_length,
    input wire logic        o_last
);

    // A result that waits must still be there on the next cycle.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output transfer dropped while stalled");

    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_event_res == mlfr_pkg::EV_DATA ||
                     o_event_res == mlfr_pkg::EV_HEADER ||
                     o_event_res == mlfr_pkg::EV_ERROR))
        else $error("unused event code on output");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res != mlfr_pkg::EV_DATA |-> o_data_byte == 8'd0)
        else $error("data byte not zero on a header or error result");

    // A dropped frame never ends a frame, and an empty header always does.
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res == mlfr_pkg::EV_ERROR |-> !o_last &&
                                                         o_frame_length != 32'd0)
        else $error("error result with last set or zero length");

    a_empty_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res == mlfr_pkg::EV_HEADER && o_frame_length == 32'd0
        |-> o_last)
        else $error("empty frame header without last");

endmodule : mlfr_checker

bind magic_length_frame_receiver_unit mlfr_checker u_mlfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_event_res    (o_event_res),
    .o_data_byte    (o_data_byte),
    .o_frame_length (o_frame_length),
    .o_last         (o_last)
);

`default_nettype wire
